// ----- src/assert_macros.svh -----
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define FCC_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

`define FCC_ASSERT(lbl, prop) \
  `FCC_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`else

`define FCC_ASSERT_CLK(lbl, clk, rstn, prop)

`define FCC_ASSERT(lbl, prop)

`endif

`endif

// ----- src/fcc_pkg.sv -----
`timescale 1ns / 1ps

package fcc_pkg;

  localparam int PLANE_COUNT_DEF = 6;
  localparam int NUM_PLANE_REGS  = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int PLANE_W         = 60;
  localparam int COEF_W          = 12;
  localparam int D_W             = 24;
  localparam int COORD_W         = 16;
  localparam int RAD_W           = 15;
  localparam int FRAC_SHIFT      = 10;
  localparam int PROD_W          = COEF_W + COORD_W;
  localparam int DIST_W          = 36;

  typedef enum logic [1:0] {
    VERDICT_INSIDE    = 2'd0,
    VERDICT_INTERSECT = 2'd1,
    VERDICT_OUTSIDE   = 2'd2
  } verdict_e;

  typedef enum logic {
    MODE_SPHERE = 1'b0,
    MODE_BOX    = 1'b1
  } mode_e;

  typedef struct packed {
    logic signed [D_W-1:0]    d;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] a;
  } plane_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  typedef struct packed {
    logic outside;
    logic straddle;
  } lane_flags_t;

endpackage

// ----- src/fcc_plane_regs.sv -----
`timescale 1ns / 1ps

module fcc_plane_regs #(
  parameter int PLANE_COUNT = fcc_pkg::PLANE_COUNT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fcc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fcc_pkg::PLANE_W-1:0]        cfg_data_i,
  output fcc_pkg::plane_t                    planes_o [PLANE_COUNT]
);

  fcc_pkg::plane_t planes_q [PLANE_COUNT];

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_plane
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        planes_q[i] <= '0;
      end else if (cfg_we_i && (cfg_index_i == fcc_pkg::CFG_IDX_W'(i))) begin
        planes_q[i] <= fcc_pkg::plane_t'(cfg_data_i);
      end
    end
    assign planes_o[i] = planes_q[i];
  end

endmodule

// ----- src/fcc_plane_lane.sv -----
`timescale 1ns / 1ps

module fcc_plane_lane (
  input  logic                                 clk_i,
  input  fcc_pkg::stage_en_t                   en_i,
  input  fcc_pkg::plane_t                      plane_i,
  input  logic                                 mode_i,
  input  logic signed [fcc_pkg::COORD_W-1:0]   x0_i,
  input  logic signed [fcc_pkg::COORD_W-1:0]   y0_i,
  input  logic signed [fcc_pkg::COORD_W-1:0]   z0_i,
  input  logic signed [fcc_pkg::COORD_W-1:0]   x1_i,
  input  logic signed [fcc_pkg::COORD_W-1:0]   y1_i,
  input  logic signed [fcc_pkg::COORD_W-1:0]   z1_i,
  input  logic                                 mode_s2_i,
  input  logic [fcc_pkg::RAD_W-1:0]            radius_s2_i,
  output fcc_pkg::lane_flags_t                 flags_o
);

  logic                                  box;
  logic signed [fcc_pkg::COORD_W-1:0]    xp, yp, zp, xn, yn, zn;
  logic signed [fcc_pkg::PROD_W-1:0]     pa_d, pb_d, pc_d, na_d, nb_d, nc_d;
  logic signed [fcc_pkg::PROD_W-1:0]     pa_q, pb_q, pc_q, na_q, nb_q, nc_q;
  logic signed [fcc_pkg::D_W-1:0]        d_q;
  logic signed [fcc_pkg::DIST_W-1:0]     d_scaled;
  logic signed [fcc_pkg::DIST_W-1:0]     dp_d, dn_d, dp_q, dn_q;
  logic signed [fcc_pkg::DIST_W-1:0]     r_ext, r_neg;

  // positive vertex picks the max corner where the normal is non-negative
  assign box = (mode_i == fcc_pkg::MODE_BOX);
  assign xp  = (box && !plane_i.a[fcc_pkg::COEF_W-1]) ? x1_i : x0_i;
  assign yp  = (box && !plane_i.b[fcc_pkg::COEF_W-1]) ? y1_i : y0_i;
  assign zp  = (box && !plane_i.c[fcc_pkg::COEF_W-1]) ? z1_i : z0_i;
  assign xn  = (box && plane_i.a[fcc_pkg::COEF_W-1]) ? x1_i : x0_i;
  assign yn  = (box && plane_i.b[fcc_pkg::COEF_W-1]) ? y1_i : y0_i;
  assign zn  = (box && plane_i.c[fcc_pkg::COEF_W-1]) ? z1_i : z0_i;

  assign pa_d = fcc_pkg::PROD_W'(plane_i.a) * fcc_pkg::PROD_W'(xp);
  assign pb_d = fcc_pkg::PROD_W'(plane_i.b) * fcc_pkg::PROD_W'(yp);
  assign pc_d = fcc_pkg::PROD_W'(plane_i.c) * fcc_pkg::PROD_W'(zp);
  assign na_d = fcc_pkg::PROD_W'(plane_i.a) * fcc_pkg::PROD_W'(xn);
  assign nb_d = fcc_pkg::PROD_W'(plane_i.b) * fcc_pkg::PROD_W'(yn);
  assign nc_d = fcc_pkg::PROD_W'(plane_i.c) * fcc_pkg::PROD_W'(zn);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      pc_q <= pc_d;
      na_q <= na_d;
      nb_q <= nb_d;
      nc_q <= nc_d;
      d_q  <= plane_i.d;
    end
  end

  assign d_scaled = fcc_pkg::DIST_W'(d_q) <<< fcc_pkg::FRAC_SHIFT;
  assign dp_d = fcc_pkg::DIST_W'(pa_q) + fcc_pkg::DIST_W'(pb_q)
              + fcc_pkg::DIST_W'(pc_q) - d_scaled;
  assign dn_d = fcc_pkg::DIST_W'(na_q) + fcc_pkg::DIST_W'(nb_q)
              + fcc_pkg::DIST_W'(nc_q) - d_scaled;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      dp_q <= dp_d;
      dn_q <= dn_d;
    end
  end

  assign r_ext = $signed(fcc_pkg::DIST_W'({radius_s2_i, {fcc_pkg::FRAC_SHIFT{1'b0}}}));
  assign r_neg = -r_ext;

  always_comb begin
    if (mode_s2_i == fcc_pkg::MODE_BOX) begin
      flags_o.outside  = (dp_q < 0);
      flags_o.straddle = (dn_q < 0);
    end else begin
      flags_o.outside  = (dp_q < r_neg);
      flags_o.straddle = (dp_q < r_ext);
    end
  end

endmodule

// ----- src/frustum_cull_classifier_unit.sv -----
`timescale 1ns / 1ps

// Classifies one sphere or axis-aligned box per transaction against all
// PLANE_COUNT (default six) frustum planes as inside, intersecting or outside.
// A new one is taken every cycle while in_stall_o is low; it passes the
// per-plane multipliers, per-plane distance adders, then the compare and
// merge into the verdict register. The user must write plane registers via
// the cfg port only while no transaction is in flight, unenforced by the block.

`include "assert_macros.svh"

module frustum_cull_classifier_unit #(
  parameter int PLANE_COUNT = fcc_pkg::PLANE_COUNT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fcc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [fcc_pkg::PLANE_W-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 mode_i,
  input  logic signed [fcc_pkg::COORD_W-1:0]   x0_i,
  input  logic signed [fcc_pkg::COORD_W-1:0]   y0_i,
  input  logic signed [fcc_pkg::COORD_W-1:0]   z0_i,
  input  logic signed [fcc_pkg::COORD_W-1:0]   x1_i,
  input  logic signed [fcc_pkg::COORD_W-1:0]   y1_i,
  input  logic signed [fcc_pkg::COORD_W-1:0]   z1_i,
  input  logic [fcc_pkg::RAD_W-1:0]            radius_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           verdict_o
);

  fcc_pkg::plane_t               planes [PLANE_COUNT];
  fcc_pkg::lane_flags_t          flags  [PLANE_COUNT];
  fcc_pkg::stage_en_t            en;
  logic                          rdy1, rdy2, rdy3;
  logic                          v1_q, v2_q, out_valid_q;
  logic                          mode_s1_q, mode_s2_q;
  logic [fcc_pkg::RAD_W-1:0]     r_s1_q, r_s2_q;
  logic [PLANE_COUNT-1:0]        out_vec, str_vec;
  fcc_pkg::verdict_e             verdict_d, verdict_q;

  fcc_plane_regs #(
    .PLANE_COUNT (PLANE_COUNT)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .planes_o    (planes)
  );

  // elastic pipeline, each stage fills when empty or draining
  assign rdy3       = !out_valid_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;
  assign en.s1      = rdy1;
  assign en.s2      = rdy2;

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_lane
    fcc_plane_lane u_lane (
      .clk_i       (clk_i),
      .en_i        (en),
      .plane_i     (planes[i]),
      .mode_i      (mode_i),
      .x0_i        (x0_i),
      .y0_i        (y0_i),
      .z0_i        (z0_i),
      .x1_i        (x1_i),
      .y1_i        (y1_i),
      .z1_i        (z1_i),
      .mode_s2_i   (mode_s2_q),
      .radius_s2_i (r_s2_q),
      .flags_o     (flags[i])
    );
    assign out_vec[i] = flags[i].outside;
    assign str_vec[i] = flags[i].straddle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        out_valid_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      mode_s1_q <= mode_i;
      r_s1_q    <= radius_i;
    end
    if (rdy2) begin
      mode_s2_q <= mode_s1_q;
      r_s2_q    <= r_s1_q;
    end
    if (rdy3) begin
      verdict_q <= verdict_d;
    end
  end

  always_comb begin
    if (|out_vec) begin
      verdict_d = fcc_pkg::VERDICT_OUTSIDE;
    end else if (|str_vec) begin
      verdict_d = fcc_pkg::VERDICT_INTERSECT;
    end else begin
      verdict_d = fcc_pkg::VERDICT_INSIDE;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  `FCC_ASSERT(a_stall_only_when_full,
    in_stall_o |-> (v1_q && v2_q && out_valid_q && out_stall_i))
  `FCC_ASSERT(a_accept_fills_s1, (in_valid_i && !in_stall_o) |=> v1_q)
  `FCC_ASSERT(a_s2_reaches_out, (v2_q && !out_valid_q) |=> out_valid_q)

endmodule

// ----- sim/frustum_cull_classifier_unit_test.sv -----
`timescale 1ns / 1ps

module frustum_cull_classifier_unit_test;
  import fcc_pkg::*;

  localparam int PLANE_COUNT = PLANE_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 64;
  localparam int RANDOM_SETTINGS = 10;
  localparam int VOLUMES_PER_SETTING = 170;

  typedef enum int {
    SET_ZERO,
    SET_ONES,
    SET_EXTREME,
    SET_NOISE,
    SET_AXIS,
    SET_TILTED,
    SET_SKEWED
  } setting_e;

  typedef struct packed {
    mode_e                     mode;
    logic signed [COORD_W-1:0] x0, y0, z0;
    logic signed [COORD_W-1:0] x1, y1, z1;
    logic [RAD_W-1:0]          radius;
  } volume_t;

  localparam int VOLUME_W = $bits(volume_t);

  typedef struct packed {
    logic [31:0] serial;
    verdict_e    verdict;
  } verdict_owed_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [PLANE_W-1:0]        cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      mode_i = 1'b0;
  logic signed [COORD_W-1:0] x0_i = '0;
  logic signed [COORD_W-1:0] y0_i = '0;
  logic signed [COORD_W-1:0] z0_i = '0;
  logic signed [COORD_W-1:0] x1_i = '0;
  logic signed [COORD_W-1:0] y1_i = '0;
  logic signed [COORD_W-1:0] z1_i = '0;
  logic [RAD_W-1:0]          radius_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [1:0]                verdict_o;

  plane_t        plane_cfg [NUM_PLANE_REGS];
  volume_t       volume_q [$];
  verdict_owed_t verdict_q [$];
  volume_t       on_bus;

  int unsigned volumes_owed = 0;
  int unsigned volumes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned settings_done = 0;
  int unsigned sphere_count = 0;
  int unsigned box_count = 0;
  int unsigned verdict_count [3] = '{0, 0, 0};
  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  int unsigned send_gap = 0;
  int unsigned recv_hold = 0;
  int unsigned quiet_cycles = 0;
  logic        drain_wait = 1'b0;
  logic        long_hold_done = 1'b0;

  frustum_cull_classifier_unit #(
    .PLANE_COUNT(PLANE_COUNT)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .x0_i       (x0_i),
    .y0_i       (y0_i),
    .z0_i       (z0_i),
    .x1_i       (x1_i),
    .y1_i       (y1_i),
    .z1_i       (z1_i),
    .radius_i   (radius_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .verdict_o  (verdict_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // signed distance at scale 2^10
  function automatic longint plane_distance(plane_t p, longint x, longint y, longint z);
    return longint'($signed(p.a)) * x + longint'($signed(p.b)) * y
         + longint'($signed(p.c)) * z - longint'($signed(p.d)) * 1024;
  endfunction

  function automatic verdict_e classify_volume(volume_t v);
    longint reach, sphere_dist, pos_dist, neg_dist;
    logic   outside, straddle, px, py, pz;
    plane_t p;
    outside = 1'b0;
    straddle = 1'b0;
    reach = longint'(v.radius) * 1024;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      p = plane_cfg[i];
      if (v.mode == MODE_SPHERE) begin
        sphere_dist = plane_distance(p, v.x0, v.y0, v.z0);
        if (sphere_dist < -reach) outside = 1'b1;
        else if (sphere_dist < reach) straddle = 1'b1;
      end else begin
        // positive vertex follows the sign of each normal component
        px = ~p.a[COEF_W-1];
        py = ~p.b[COEF_W-1];
        pz = ~p.c[COEF_W-1];
        pos_dist = plane_distance(p, px ? v.x1 : v.x0, py ? v.y1 : v.y0, pz ? v.z1 : v.z0);
        neg_dist = plane_distance(p, px ? v.x0 : v.x1, py ? v.y0 : v.y1, pz ? v.z0 : v.z1);
        if (pos_dist < 0) outside = 1'b1;
        else if (neg_dist < 0) straddle = 1'b1;
      end
    end
    if (outside) return VERDICT_OUTSIDE;
    if (straddle) return VERDICT_INTERSECT;
    return VERDICT_INSIDE;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[COORD_W-1:0];
  endfunction

  function automatic volume_t make_volume(mode_e m, int x0, int y0, int z0,
                                          int x1, int y1, int z1, int r);
    volume_t v;
    v.mode = m;
    v.x0 = x0[COORD_W-1:0];
    v.y0 = y0[COORD_W-1:0];
    v.z0 = z0[COORD_W-1:0];
    v.x1 = x1[COORD_W-1:0];
    v.y1 = y1[COORD_W-1:0];
    v.z1 = z1[COORD_W-1:0];
    v.radius = r[RAD_W-1:0];
    return v;
  endfunction

  function automatic volume_t random_volume(int span);
    volume_t v;
    int cx, cy, cz, ex, ey, ez;
    logic signed [COORD_W-1:0] swap;
    if ($urandom_range(0, 9) == 0)
      return VOLUME_W'({$urandom, $urandom, $urandom, $urandom});
    cx = int'($urandom_range(0, 2 * span)) - span;
    cy = int'($urandom_range(0, 2 * span)) - span;
    cz = int'($urandom_range(0, 2 * span)) - span;
    v.mode = ($urandom_range(0, 1) == 1) ? MODE_BOX : MODE_SPHERE;
    v.x1 = COORD_W'($urandom);
    v.y1 = COORD_W'($urandom);
    v.z1 = COORD_W'($urandom);
    v.radius = RAD_W'($urandom);
    if (v.mode == MODE_SPHERE) begin
      v.x0 = clamp_coord(cx);
      v.y0 = clamp_coord(cy);
      v.z0 = clamp_coord(cz);
      if ($urandom_range(0, 3) != 0) v.radius = RAD_W'($urandom_range(0, span / 3));
    end else begin
      ex = int'($urandom_range(0, span / 3));
      ey = int'($urandom_range(0, span / 3));
      ez = int'($urandom_range(0, span / 3));
      v.x0 = clamp_coord(cx - ex);
      v.y0 = clamp_coord(cy - ey);
      v.z0 = clamp_coord(cz - ez);
      v.x1 = clamp_coord(cx + ex);
      v.y1 = clamp_coord(cy + ey);
      v.z1 = clamp_coord(cz + ez);
      if ($urandom_range(0, 15) == 0) begin
        swap = v.x0;
        v.x0 = v.x1;
        v.x1 = swap;
      end
    end
    return v;
  endfunction

  // inward facing plane of an axis box, normal tilted by up to jit
  function automatic plane_t frustum_plane(int idx, int jit, int half_width);
    int comp [3];
    plane_t p;
    for (int k = 0; k < 3; k++) comp[k] = int'($urandom_range(0, 2 * jit)) - jit;
    comp[idx / 2] += (idx % 2 == 0) ? 1024 : -1024;
    for (int k = 0; k < 3; k++) begin
      if (comp[k] > 2047) comp[k] = 2047;
      else if (comp[k] < -2048) comp[k] = -2048;
    end
    p.a = comp[0][COEF_W-1:0];
    p.b = comp[1][COEF_W-1:0];
    p.c = comp[2][COEF_W-1:0];
    p.d = D_W'(-half_width);
    return p;
  endfunction

  function automatic logic signed [COEF_W-1:0] extreme_coef();
    case ($urandom_range(0, 2))
      0: return {1'b1, {(COEF_W-1){1'b0}}};
      1: return {1'b0, {(COEF_W-1){1'b1}}};
      default: return '0;
    endcase
  endfunction

  function automatic plane_t setting_plane(setting_e kind, int idx, int half_width);
    plane_t p;
    case (kind)
      SET_ZERO: p = '0;
      SET_ONES: p = '1;
      SET_EXTREME: begin
        p.a = extreme_coef();
        p.b = extreme_coef();
        p.c = extreme_coef();
        case ($urandom_range(0, 2))
          0: p.d = {1'b1, {(D_W-1){1'b0}}};
          1: p.d = {1'b0, {(D_W-1){1'b1}}};
          default: p.d = '0;
        endcase
      end
      SET_NOISE: p = PLANE_W'({$urandom, $urandom});
      SET_AXIS: p = frustum_plane(idx, 0, half_width);
      SET_TILTED: p = frustum_plane(idx, 300, half_width);
      default: p = frustum_plane(idx, 1024, half_width);
    endcase
    return p;
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 45;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 30) $display("mismatch: %s", what);
  endtask

  task automatic wait_idle();
    while (volumes_owed != 0) @(posedge clk_i);
  endtask

  // indexes past the last plane get noise and must be ignored
  task automatic program_planes(setting_e kind, int half_width);
    plane_t p;
    for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
      if (i < NUM_PLANE_REGS) begin
        p = setting_plane(kind, i, half_width);
        plane_cfg[i] = p;
      end else begin
        p = PLANE_W'({$urandom, $urandom});
      end
      cfg_we_i <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(i);
      cfg_data_i <= p;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_done++;
  endtask

  task automatic queue_volume(volume_t v);
    volume_q.push_back(v);
    volumes_owed++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        verdict_q.push_back('{serial: volumes_sent, verdict: classify_volume(on_bus)});
        volumes_sent++;
        if (on_bus.mode == MODE_SPHERE) sphere_count++;
        else box_count++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (drain_wait && verdict_q.size() == 0) drain_wait = 1'b0;
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (drain_wait || volume_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
          send_gap = $urandom_range(0, 16);
          if ($urandom_range(0, 39) == 0) drain_wait = 1'b1;
          in_valid_i <= 1'b0;
        end else begin
          on_bus = volume_q.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= on_bus.mode;
          x0_i <= on_bus.x0;
          y0_i <= on_bus.y0;
          z0_i <= on_bus.z0;
          x1_i <= on_bus.x1;
          y1_i <= on_bus.y1;
          z1_i <= on_bus.z1;
          radius_i <= on_bus.radius;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (verdict_o != 2'd3) verdict_count[verdict_o]++;
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with no volume outstanding", verdict_o));
        end else begin
          if (verdict_o !== verdict_q[0].verdict)
            report_mismatch($sformatf("volume %0d: verdict %0d, expected %0d",
                                      verdict_q[0].serial, verdict_o, verdict_q[0].verdict));
          void'(verdict_q.pop_front());
          volumes_owed--;
        end
      end
      if (recv_hold != 0) begin
        recv_hold--;
        out_stall_i <= 1'b1;
      end else if (!long_hold_done && results_seen >= 400) begin
        long_hold_done = 1'b1;
        recv_hold = LONG_HOLD - 1;
        out_stall_i <= 1'b1;
      end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
        recv_hold = $urandom_range(0, 16);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || volumes_owed == 0) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no transaction for %0d cycles, %0d verdicts owed", quiet_cycles, volumes_owed);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    setting_e plan [RANDOM_SETTINGS];
    int half_width;
    int span;
    plan = '{SET_AXIS, SET_ONES, SET_TILTED, SET_EXTREME, SET_AXIS,
             SET_NOISE, SET_SKEWED, SET_ZERO, SET_TILTED, SET_AXIS};
    for (int i = 0; i < NUM_PLANE_REGS; i++) plane_cfg[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all planes zero after reset
    in_idle_pct = 20;
    out_idle_pct = 20;
    queue_volume(make_volume(MODE_SPHERE, 32767, -32768, 32767, 0, 0, 0, 32767));
    queue_volume(make_volume(MODE_SPHERE, -32768, -32768, -32768, 0, 0, 0, 0));
    queue_volume(make_volume(MODE_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
    queue_volume(make_volume(MODE_BOX, 32767, 32767, 32767, -32768, -32768, -32768, 32767));
    wait_idle();

    // axis cube of half width 1000, distances exact
    program_planes(SET_AXIS, 1000);
    queue_volume(make_volume(MODE_SPHERE, 0, 0, 0, 0, 0, 0, 0));
    queue_volume(make_volume(MODE_SPHERE, 1000, 0, 0, 0, 0, 0, 0));
    queue_volume(make_volume(MODE_SPHERE, 1001, 0, 0, 0, 0, 0, 0));
    queue_volume(make_volume(MODE_SPHERE, 990, 0, 0, 0, 0, 0, 10));
    queue_volume(make_volume(MODE_SPHERE, 990, 0, 0, 0, 0, 0, 11));
    queue_volume(make_volume(MODE_SPHERE, 0, -1010, 0, 0, 0, 0, 10));
    queue_volume(make_volume(MODE_SPHERE, 0, 0, -1011, 0, 0, 0, 10));
    queue_volume(make_volume(MODE_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767));
    queue_volume(make_volume(MODE_SPHERE, -32768, 0, 0, 32767, 32767, 32767, 0));
    queue_volume(make_volume(MODE_SPHERE, 0, 0, 0, -32768, -32768, -32768, 32767));
    queue_volume(make_volume(MODE_BOX, -500, -500, -500, 500, 500, 500, 0));
    queue_volume(make_volume(MODE_BOX, -1000, -1000, -1000, 1000, 1000, 1000, 0));
    queue_volume(make_volume(MODE_BOX, -1001, -1000, -1000, 1000, 1000, 1000, 0));
    queue_volume(make_volume(MODE_BOX, 1001, 0, 0, 2000, 0, 0, 0));
    queue_volume(make_volume(MODE_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
    queue_volume(make_volume(MODE_BOX, 500, 500, 500, -500, -500, -500, 32767));
    queue_volume(make_volume(MODE_BOX, 2000, 0, 0, -2000, 0, 0, 0));
    queue_volume(make_volume(MODE_BOX, -32768, -32768, -32768, -32768, -32768, -32768, 0));
    wait_idle();

    for (int s = 0; s < RANDOM_SETTINGS; s++) begin
      half_width = $urandom_range(200, 24000);
      span = (plan[s] >= SET_AXIS) ? half_width + half_width / 4 : 32767;
      program_planes(plan[s], half_width);
      if (s == RANDOM_SETTINGS - 1) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct = pick_idle_pct();
        out_idle_pct = pick_idle_pct();
      end
      repeat (VOLUMES_PER_SETTING) queue_volume(random_volume(span));
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    $display("classified %0d volumes (%0d spheres, %0d boxes) under %0d plane settings",
             volumes_sent, sphere_count, box_count, settings_done);
    $display("verdicts: %0d inside, %0d intersecting, %0d outside, %0d mismatches",
             verdict_count[0], verdict_count[1], verdict_count[2], mismatches);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
